// ===== rtl/fpba_pkg.sv =====
package fpba_pkg;

    localparam int BLK_IDX_W  = 4;
    localparam int BLK_CNT_W  = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NONE  = 2'd3
    } t_fit_mode;

    typedef enum logic [1:0] {
        ST_LOADED  = 2'd0,
        ST_ALLOC   = 2'd1,
        ST_UNALLOC = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic      clr;
        logic      vld;
        t_fit_mode mode;
    } t_sel_ctl;

endpackage

// ===== rtl/fit_policy_block_allocator_core.sv =====
// Fit-policy block allocator.
//
// Issue an item by raising start while busy is low; it is taken at that edge.
// A load item (action 0) writes block_index's size and frees it; its result
// is strobed on o_done in the cycle after the start cycle. An allocate item
// (action 1) walks the active blocks one per cycle through the table RAM and
// picks a block under the current fit mode; it runs the scan, last and commit
// states and its result is registered in the commit state. With no active
// blocks or the unused mode, the unallocated result comes as for a load.
// Throughput is one item per result: busy stays high until the commit cycle,
// and the next item may start in the cycle o_done is high. The scan through
// the single read port of the table RAM sets that figure. Each result is
// strobed on o_done for exactly one cycle; the receiver cannot stall it.
// Write fit_mode and block_count on the config port only while the block is
// idle. Reset clears the occupied flags, the mode (first fit) and the block
// count (16); block sizes are undefined until loaded.
module fit_policy_block_allocator_core
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_action,
    input  logic [BLK_IDX_W-1:0]  i_block_index,
    input  logic [SIZE_BITS-1:0]  i_size_value,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [BLK_IDX_W-1:0]  o_chosen_block,
    output logic [SIZE_BITS-1:0]  o_space_left,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int NCNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int CNT_W  = (NCNT_W > BLK_CNT_W) ? NCNT_W : BLK_CNT_W;
    localparam int WORD_W = SIZE_BITS + 1;

    t_state                 r_state, n_state;
    t_fit_mode              r_fit_mode;
    logic [BLK_CNT_W-1:0]   r_block_count;
    logic [IDX_W-1:0]       r_addr, n_addr;
    logic [SIZE_BITS-1:0]   r_req, n_req;
    logic                   r_cmp_vld;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic [NUM_BLOCKS-1:0]  r_vld;
    logic                   r_done, n_done;
    t_status                r_status, n_status;
    logic [BLK_IDX_W-1:0]   r_chosen, n_chosen;
    logic [SIZE_BITS-1:0]   r_space, n_space;

    logic [CNT_W-1:0]       cnt_ext;
    logic [CNT_W-1:0]       act_n;
    logic                   load_in_range;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [WORD_W-1:0]      ram_rdata;
    logic                   rd_flag;
    logic                   sel_clr;
    t_sel_ctl               sel_ctl;
    logic                   best_have;
    logic [IDX_W-1:0]       best_idx;
    logic [SIZE_BITS-1:0]   best_space;
    logic                   best_flag;
    logic [SIZE_BITS-1:0]   new_space;
    logic                   new_flag;

    assign cnt_ext = CNT_W'(r_block_count);
    assign act_n   = (cnt_ext > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : cnt_ext;
    assign load_in_range = ((CNT_W + 1)'(i_block_index) < (CNT_W + 1)'(NUM_BLOCKS));

    // a flag never written since reset reads as free
    assign rd_flag = ram_rdata[SIZE_BITS] && r_vld[r_cmp_idx];

    assign new_space = (r_fit_mode == FIT_FIRST) ? best_space : best_space - r_req;
    assign new_flag  = (r_fit_mode == FIT_BEST) ? best_flag : 1'b1;

    assign sel_ctl.clr  = sel_clr;
    assign sel_ctl.vld  = r_cmp_vld;
    assign sel_ctl.mode = r_fit_mode;

    fpba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    fpba_sel #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sel_ctl),
        .i_idx   (r_cmp_idx),
        .i_space (ram_rdata[SIZE_BITS-1:0]),
        .i_flag  (rd_flag),
        .i_req   (r_req),
        .o_have  (best_have),
        .o_idx   (best_idx),
        .o_space (best_space),
        .o_flag  (best_flag)
    );

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_req     = r_req;
        n_done    = 1'b0;
        n_status  = r_status;
        n_chosen  = r_chosen;
        n_space   = r_space;
        ram_we    = 1'b0;
        ram_waddr = best_idx;
        ram_wdata = {new_flag, new_space};
        ram_re    = 1'b0;
        sel_clr   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_action == ACT_LOAD) begin
                        n_done   = 1'b1;
                        n_status = ST_LOADED;
                        n_chosen = i_block_index;
                        if (load_in_range) begin
                            ram_we    = 1'b1;
                            ram_waddr = IDX_W'(i_block_index);
                            ram_wdata = {1'b0, i_size_value};
                            n_space   = i_size_value;
                        end else begin
                            n_space = '0;
                        end
                    end else if ((act_n == '0) || (r_fit_mode == FIT_NONE)) begin
                        n_done   = 1'b1;
                        n_status = ST_UNALLOC;
                        n_chosen = '0;
                        n_space  = '0;
                    end else begin
                        n_req   = i_size_value;
                        n_addr  = '0;
                        sel_clr = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ram_re = 1'b1;
                if (CNT_W'(r_addr) == act_n - CNT_W'(1)) begin
                    n_state = S_LAST;
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end
            S_LAST: begin
                // last compare lands in the selector this cycle
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (best_have) begin
                    ram_we   = 1'b1;
                    n_status = ST_ALLOC;
                    n_chosen = BLK_IDX_W'(best_idx);
                    n_space  = new_space;
                end else begin
                    n_status = ST_UNALLOC;
                    n_chosen = '0;
                    n_space  = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fit_mode    <= FIT_FIRST;
            r_block_count <= BLK_CNT_W'(16);
            r_cmp_vld     <= 1'b0;
            r_vld         <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == S_SCAN);
            r_done    <= n_done;
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FIT_MODE:    r_fit_mode    <= t_fit_mode'(i_cfg_data[1:0]);
                    CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[BLK_CNT_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_req     <= n_req;
        r_cmp_idx <= r_addr;
        r_status  <= n_status;
        r_chosen  <= n_chosen;
        r_space   <= n_space;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_chosen_block = r_chosen;
    assign o_space_left   = r_space;

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ACT_LOAD)) |=> (o_done && (o_status == ST_LOADED)))
        else $error("load item gave no loaded result");

    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |=> (o_done && (r_state == S_IDLE)))
        else $error("commit gave no result");

    a_unalloc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_UNALLOC)) |-> ((o_chosen_block == '0) && (o_space_left == '0)))
        else $error("unallocated result carries a block");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) || (r_state == S_LAST)) |-> (!ram_we && !o_done))
        else $error("table written or result given during scan");

endmodule

// ===== rtl/fpba_ram.sv =====
module fpba_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fpba_sel.sv =====
module fpba_sel
    import fpba_pkg::*;
#(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_sel_ctl             i_ctl,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [SIZE_BITS-1:0] i_space,
    input  logic                 i_flag,
    input  logic [SIZE_BITS-1:0] i_req,
    output logic                 o_have,
    output logic [IDX_W-1:0]     o_idx,
    output logic [SIZE_BITS-1:0] o_space,
    output logic                 o_flag
);

    logic                 r_have;
    logic [IDX_W-1:0]     r_idx;
    logic [SIZE_BITS-1:0] r_space;
    logic                 r_flag;
    logic                 fits;
    logic                 take;

    assign fits = (i_space >= i_req);

    // strict compares keep ties on the lowest index
    always_comb begin
        unique case (i_ctl.mode)
            FIT_FIRST: take = fits && !i_flag && !r_have;
            FIT_BEST:  take = fits && (!r_have || (i_space < r_space));
            FIT_WORST: take = fits && !i_flag && (!r_have || (i_space > r_space));
            FIT_NONE:  take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clr) begin
            r_have <= 1'b0;
        end else if (i_ctl.vld && take) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.clr && i_ctl.vld && take) begin
            r_idx   <= i_idx;
            r_space <= i_space;
            r_flag  <= i_flag;
        end
    end

    assign o_have  = r_have;
    assign o_idx   = r_idx;
    assign o_space = r_space;
    assign o_flag  = r_flag;

endmodule
